// ===== hdl/dsd_pkg.sv =====
// Shared constants, types and functions of the decimal digit segment driver.
`default_nettype none
package dsd_pkg;

  localparam int NUM_DISPLAYS = 4;
  localparam int DISPLAYS_EFF = (NUM_DISPLAYS < 1) ? 1 : NUM_DISPLAYS;

  localparam int VALUE_W = 16;
  localparam int PORT_W  = 12;
  localparam int SEG_W   = 8;
  localparam int SEL_W   = 4;
  localparam int DIGIT_W = 4;
  localparam int POS_W   = 3;

  // Reciprocal of ten: (x * 52429) >> 19 is exact for every 16-bit x.
  localparam logic [15:0] RECIP_TEN = 16'd52429;
  localparam int          RECIP_SHIFT = 19;

  typedef struct packed {
    logic load;
    logic step;
  } dsd_cmd_t;

  typedef struct packed {
    logic final_digit;
  } dsd_status_t;

  function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0: s = 8'h3f;
      4'd1: s = 8'h06;
      4'd2: s = 8'h5b;
      4'd3: s = 8'h4f;
      4'd4: s = 8'h66;
      4'd5: s = 8'h6d;
      4'd6: s = 8'h7d;
      4'd7: s = 8'h07;
      4'd8: s = 8'h7f;
      4'd9: s = 8'h6f;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // Display select for a digit position, wrapping round the displays. A display
  // index beyond the four select bits of the port word leaves the select empty.
  function automatic logic [SEL_W-1:0] select_bits(input logic [POS_W-1:0] pos);
    logic [POS_W:0] m;
    logic [SEL_W-1:0] sel;
    m = {1'b0, pos};
    for (int i = 0; i < (1 << POS_W); i++) begin
      if (m >= (POS_W+1)'(DISPLAYS_EFF)) begin
        m = m - (POS_W+1)'(DISPLAYS_EFF);
      end
    end
    sel = '0;
    for (int j = 0; j < SEL_W; j++) begin
      if (m == (POS_W+1)'(j)) begin
        sel[j] = 1'b1;
      end
    end
    return sel;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/dsd_ctrl.sv =====
// Controller state machine of the decimal digit segment driver.
`default_nettype none
module dsd_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire dsd_pkg::dsd_status_t status,
  output dsd_pkg::dsd_cmd_t        cmd,
  output logic                     busy
);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t state;

  always_comb begin
    cmd.load = start && !busy;
    cmd.step = (state == ST_RUN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_RUN;
            busy  <= 1'b1;
          end
        end
        ST_RUN: begin
          if (status.final_digit) begin
            state <= ST_IDLE;
            busy  <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/dsd_datapath.sv =====
// Datapath of the decimal digit segment driver: quotient, position and result registers.
`default_nettype none
module dsd_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire dsd_pkg::dsd_cmd_t                   cmd,
  input  wire logic [dsd_pkg::VALUE_W-1:0]         value,
  output dsd_pkg::dsd_status_t                     status,
  output logic                                     strobe,
  output logic [dsd_pkg::PORT_W-1:0]               port_word,
  output logic [dsd_pkg::DIGIT_W-1:0]              digit,
  output logic [dsd_pkg::POS_W-1:0]                digit_position,
  output logic                                     last
);

  logic [dsd_pkg::VALUE_W-1:0]   quotient;
  logic [dsd_pkg::POS_W-1:0]     position;
  logic [2*dsd_pkg::VALUE_W-1:0] product;
  logic [dsd_pkg::VALUE_W-1:0]   quotient_next;
  logic [dsd_pkg::VALUE_W-1:0]   times_ten;
  logic [dsd_pkg::VALUE_W-1:0]   remainder;
  logic [dsd_pkg::DIGIT_W-1:0]   cur_digit;

  always_comb begin
    product       = quotient * dsd_pkg::RECIP_TEN;
    quotient_next = dsd_pkg::VALUE_W'(product >> dsd_pkg::RECIP_SHIFT);
    times_ten     = (quotient_next << 3) + (quotient_next << 1);
    remainder     = quotient - times_ten;
    cur_digit     = remainder[dsd_pkg::DIGIT_W-1:0];
    status.final_digit = (quotient_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quotient <= value;
      position <= '0;
    end else if (cmd.step) begin
      quotient <= quotient_next;
      position <= position + 1'b1;
    end
    if (cmd.step) begin
      port_word      <= {dsd_pkg::select_bits(position), dsd_pkg::seg_pattern(cur_digit)};
      digit          <= cur_digit;
      digit_position <= position;
      last           <= status.final_digit;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/decimal_digit_segment_driver_unit.sv =====
// Top level of the decimal digit segment driver: controller plus datapath.
// Timing: start taken in idle enters the run state, from which the first digit is registered
// onto the outputs, then one per cycle. Throughput: a value of n decimal digits (1 to 5) keeps
// busy high until its last digit is shown; a new start is taken only while busy is low, and the
// shared divide-by-ten step handles one digit per cycle. Results cannot be stalled by the receiver.
// Reset: synchronous rst returns the controller to idle and clears busy and strobe.
`default_nettype none
module decimal_digit_segment_driver_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [dsd_pkg::VALUE_W-1:0] value,
  output logic                             busy,
  output logic                             strobe,
  output logic [dsd_pkg::PORT_W-1:0]       port_word,
  output logic [dsd_pkg::DIGIT_W-1:0]      digit,
  output logic [dsd_pkg::POS_W-1:0]        digit_position,
  output logic                             last
);

  dsd_pkg::dsd_cmd_t    cmd;
  dsd_pkg::dsd_status_t status;

  dsd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  dsd_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .value          (value),
    .status         (status),
    .strobe         (strobe),
    .port_word      (port_word),
    .digit          (digit),
    .digit_position (digit_position),
    .last           (last)
  );

`ifndef SYNTH
  // A transaction taken makes the block busy on the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised after start");

  // Digits of one value follow each other without a gap.
  a_digit_run: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe) else $error("gap inside a digit run");

  // The block goes idle exactly as the most significant digit is shown.
  a_end_run: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> strobe && last) else $error("run ended without last digit");

  // Every digit produced is decimal.
  a_decimal: assert property (@(posedge clk) disable iff (rst)
    strobe |-> digit <= 4'd9) else $error("digit out of range");
`endif

endmodule
`default_nettype wire
